### sv/onod_pkg.sv
// ----------------------------------------------------------------------------
// onod_pkg
// Shared types and constants of the object/normal outline detector.
// ----------------------------------------------------------------------------
package onod_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned ID_BITS_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned NRM_BITS = 48;
  localparam int unsigned RGB_BITS = 24;

  // neighborhood taps as they travel through the queue
  localparam int unsigned N_TAPS     = 5;
  localparam int unsigned TAP_CENTER = 0;
  localparam int unsigned TAP_LEFT   = 1;
  localparam int unsigned TAP_RIGHT  = 2;
  localparam int unsigned TAP_UP     = 3;
  localparam int unsigned TAP_DOWN   = 4;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_OUTLINE   = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic [10:0] WIDTH_RST     = 11'd800;
  localparam logic [11:0] HEIGHT_RST    = 12'd600;
  localparam logic [23:0] OUTLINE_RST   = 24'h0A0A0A;
  localparam logic [15:0] THRESHOLD_RST = 16'd9830;

  localparam logic [11:0] MIN_DIM = 12'd3;

  typedef struct packed {
    logic interior;
    logic frame_end;
  } ctrl_t;

endpackage

### sv/onod_ram.sv
// ----------------------------------------------------------------------------
// onod_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module onod_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### sv/onod_fifo.sv
// ----------------------------------------------------------------------------
// onod_fifo
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
module onod_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### sv/onod_front.sv
// ----------------------------------------------------------------------------
// onod_front
// Accepts pixels and flush beats, keeps the raster counters and line stores,
// and gathers each center pixel's neighborhood for the queue.
// ----------------------------------------------------------------------------
module onod_front #(
  parameter int unsigned MAX_WIDTH = onod_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ID_BITS   = onod_pkg::ID_BITS_DEF,
  parameter int unsigned DEPTH     = onod_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [7:0]                    object_id_i,
  input  logic signed [15:0]            normal_x_i,
  input  logic signed [15:0]            normal_y_i,
  input  logic signed [15:0]            normal_z_i,
  input  logic [7:0]                    color_red_i,
  input  logic [7:0]                    color_green_i,
  input  logic [7:0]                    color_blue_i,
  input  logic [10:0]                   cfg_width_i,
  input  logic [11:0]                   cfg_height_i,
  input  logic [$clog2(DEPTH+1)-1:0]    q_count_i,
  output logic                          push_o,
  output onod_pkg::ctrl_t               ctrl_o,
  output logic [onod_pkg::N_TAPS-1:0][ID_BITS-1:0]            ids_o,
  output logic [onod_pkg::N_TAPS-1:0][onod_pkg::NRM_BITS-1:0] nrms_o,
  output logic [onod_pkg::RGB_BITS-1:0] color_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned EW  = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int unsigned QCW = $clog2(DEPTH + 1);
  localparam int unsigned NB  = onod_pkg::NRM_BITS;
  localparam int unsigned CB  = onod_pkg::RGB_BITS;

  logic [CW-1:0] col_q, drain_q;
  logic [11:0]   row_q;

  logic [EW-1:0] w_raw, w_eff;
  logic [11:0]   h_eff;
  logic          accept, pix, flush;
  logic          col_last, drain_last, row_ge_h, interior;
  logic [CW-1:0] col_inc;

  logic [ID_BITS+7:0] id_wide;
  logic [ID_BITS-1:0] id_in;
  logic [NB-1:0]      nrm_in;
  logic [CB-1:0]      rgb_in;

  logic               s1_valid_q, s1_flush_q, s1_czero_q;
  onod_pkg::ctrl_t    s1_ctrl_q;
  logic [ID_BITS-1:0] s1_id_q;
  logic [NB-1:0]      s1_nrm_q;

  logic [ID_BITS-1:0] win_c_id_q, win_r_id_q;
  logic [NB-1:0]      win_c_nrm_q, win_r_nrm_q;

  logic [CW:0]        addr_a, addr_b, addr_w;
  logic [ID_BITS-1:0] id_a, id_b;
  logic [NB-1:0]      nrm_a, nrm_b;
  logic [CB-1:0]      col_a, col_b;

  // clamp geometry to what the stores can hold
  assign w_raw = EW'(cfg_width_i);
  always_comb begin
    if (w_raw < EW'(onod_pkg::MIN_DIM)) begin
      w_eff = EW'(onod_pkg::MIN_DIM);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end
  assign h_eff = (cfg_height_i < onod_pkg::MIN_DIM) ? onod_pkg::MIN_DIM : cfg_height_i;

  // credit: queue entries plus the beat in the read stage
  assign in_stall_o = ((QCW+1)'(q_count_i) + (QCW+1)'(s1_valid_q)) >= (QCW+1)'(DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign row_ge_h   = row_q >= h_eff;
  assign pix        = accept && !func_i && !row_ge_h;
  assign flush      = accept && func_i && row_ge_h;
  assign col_inc    = col_q + 1'b1;
  assign col_last   = (EW'(col_q) + EW'(1)) >= w_eff;
  assign drain_last = (EW'(drain_q) + EW'(1)) >= w_eff;
  assign interior   = (row_q >= 12'd2) && (col_q != '0) && !col_last;

  assign id_wide = (ID_BITS+8)'(object_id_i);
  assign id_in   = id_wide[ID_BITS-1:0];
  assign nrm_in  = {normal_x_i, normal_y_i, normal_z_i};
  assign rgb_in  = {color_red_i, color_green_i, color_blue_i};

  // bank row_q[0] holds the row being written (and row r-2 before the write);
  // at column 0 port a fetches the first center pixel instead of the up one
  assign addr_w = {row_q[0], col_q};
  assign addr_a = {(col_q == '0) ? ~row_q[0] : row_q[0], col_q};
  assign addr_b = {~row_q[0], col_inc};

  onod_ram #(.WIDTH(ID_BITS), .DEPTH(2 << CW)) u_id_ram (
    .clk_i     (clk_i),
    .we_i      (pix),
    .waddr_i   (addr_w),
    .wdata_i   (id_in),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (id_a),
    .rdata_b_o (id_b)
  );

  onod_ram #(.WIDTH(NB), .DEPTH(2 << CW)) u_nrm_ram (
    .clk_i     (clk_i),
    .we_i      (pix),
    .waddr_i   (addr_w),
    .wdata_i   (nrm_in),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (nrm_a),
    .rdata_b_o (nrm_b)
  );

  onod_ram #(.WIDTH(CB), .DEPTH(1 << CW)) u_color_ram (
    .clk_i     (clk_i),
    .we_i      (pix),
    .waddr_i   (col_q),
    .wdata_i   (rgb_in),
    .raddr_a_i (col_q),
    .raddr_b_i (drain_q),
    .rdata_a_o (col_a),
    .rdata_b_o (col_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      drain_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= (pix && (row_q != '0)) || flush;
      if (pix) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_inc;
        end
      end
      if (flush) begin
        if (drain_last) begin
          drain_q <= '0;
          row_q   <= '0;
          col_q   <= '0;
        end else begin
          drain_q <= drain_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_q          <= func_i;
      s1_czero_q          <= (col_q == '0);
      s1_ctrl_q.interior  <= !func_i && interior;
      s1_ctrl_q.frame_end <= func_i && drain_last;
      s1_id_q             <= id_in;
      s1_nrm_q            <= nrm_in;
    end
    if (s1_valid_q && !s1_flush_q) begin
      if (s1_czero_q) begin
        win_c_id_q  <= id_a;
        win_c_nrm_q <= nrm_a;
      end else begin
        win_c_id_q  <= win_r_id_q;
        win_c_nrm_q <= win_r_nrm_q;
      end
      win_r_id_q  <= id_b;
      win_r_nrm_q <= nrm_b;
    end
  end

  assign push_o  = s1_valid_q;
  assign ctrl_o  = s1_ctrl_q;
  assign color_o = s1_flush_q ? col_b : col_a;

  always_comb begin
    ids_o[onod_pkg::TAP_CENTER]  = win_r_id_q;
    ids_o[onod_pkg::TAP_LEFT]    = win_c_id_q;
    ids_o[onod_pkg::TAP_RIGHT]   = id_b;
    ids_o[onod_pkg::TAP_UP]      = id_a;
    ids_o[onod_pkg::TAP_DOWN]    = s1_id_q;
    nrms_o[onod_pkg::TAP_CENTER] = win_r_nrm_q;
    nrms_o[onod_pkg::TAP_LEFT]   = win_c_nrm_q;
    nrms_o[onod_pkg::TAP_RIGHT]  = nrm_b;
    nrms_o[onod_pkg::TAP_UP]     = nrm_a;
    nrms_o[onod_pkg::TAP_DOWN]   = s1_nrm_q;
  end

endmodule

### sv/onod_back.sv
// ----------------------------------------------------------------------------
// onod_back
// Takes neighborhoods off the queue, forms the normal dot products and
// decides edge or pass-through into the output register.
// ----------------------------------------------------------------------------
module onod_back #(
  parameter int unsigned ID_BITS = onod_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_nonempty_i,
  output logic                          pop_o,
  input  onod_pkg::ctrl_t               ctrl_i,
  input  logic [onod_pkg::N_TAPS-1:0][ID_BITS-1:0]            ids_i,
  input  logic [onod_pkg::N_TAPS-1:0][onod_pkg::NRM_BITS-1:0] nrms_i,
  input  logic [onod_pkg::RGB_BITS-1:0] color_i,
  input  logic [23:0]                   cfg_outline_i,
  input  logic signed [15:0]            cfg_threshold_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic                          is_edge_o,
  output logic                          frame_end_o
);

  localparam int unsigned NN = onod_pkg::N_TAPS - 1;

  logic advance;

  logic               p_valid_q;
  onod_pkg::ctrl_t    p_ctrl_q;
  logic               p_id_diff_q, p_cid_nz_q;
  logic [23:0]        p_color_q;
  logic signed [31:0] prod_q [NN][3];

  logic               id_diff;
  logic signed [33:0] thr;
  logic signed [33:0] dot [NN];
  logic               low_dot, edge_hit;

  logic               out_valid_q, out_edge_q, out_end_q;
  logic [23:0]        out_rgb_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && q_nonempty_i;

  always_comb begin
    id_diff = 1'b0;
    for (int k = 1; k < onod_pkg::N_TAPS; k++) begin
      if (ids_i[k] != ids_i[onod_pkg::TAP_CENTER]) begin
        id_diff = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p_ctrl_q    <= ctrl_i;
      p_id_diff_q <= id_diff;
      p_cid_nz_q  <= ids_i[onod_pkg::TAP_CENTER] != '0;
      p_color_q   <= color_i;
      for (int k = 0; k < NN; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[k][j] <= $signed(nrms_i[onod_pkg::TAP_CENTER][16*j +: 16])
                        * $signed(nrms_i[k+1][16*j +: 16]);
        end
      end
    end
  end

  // threshold in Q6.28
  assign thr = {{4{cfg_threshold_i[15]}}, cfg_threshold_i, 14'd0};

  always_comb begin
    low_dot = 1'b0;
    for (int k = 0; k < NN; k++) begin
      dot[k] = 34'(prod_q[k][0]) + 34'(prod_q[k][1]) + 34'(prod_q[k][2]);
      if (dot[k] < thr) begin
        low_dot = 1'b1;
      end
    end
  end

  assign edge_hit = p_ctrl_q.interior && p_cid_nz_q && (p_id_diff_q || low_dot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      p_valid_q   <= q_nonempty_i;
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rgb_q  <= edge_hit ? cfg_outline_i : p_color_q;
      out_edge_q <= edge_hit;
      out_end_q  <= p_ctrl_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_rgb_q[23:16];
  assign out_green_o = out_rgb_q[15:8];
  assign out_blue_o  = out_rgb_q[7:0];
  assign is_edge_o   = out_edge_q;
  assign frame_end_o = out_end_q;

endmodule

### sv/object_normal_outline_detector_top.sv
// ----------------------------------------------------------------------------
// object_normal_outline_detector_top
// Screen-space outline detection on a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one beat per clock: a pixel beat or a flush beat. The pixel at
// (row-1, col) leaves when the pixel at (row, col) arrives, so output lags
// input by one row; after the last row, one flush beat per pixel of that row
// drains it, the last carrying frame_end. Sustained rate is one beat per
// cycle while the input is not stalled, with one write and two reads of
// the line stores per beat; output is registered after the product stage.
// Input stalls only when the four-entry queue between the neighborhood front
// and the dot-product back, counting the beat in the read stage, is full.
// Line stores need no clearing after reset.
module object_normal_outline_detector_top #(
  parameter int unsigned MAX_WIDTH = onod_pkg::MAX_WIDTH_DEF,
  parameter int unsigned ID_BITS   = onod_pkg::ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         object_id_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [7:0]         color_red_i,
  input  logic [7:0]         color_green_i,
  input  logic [7:0]         color_blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic               is_edge_o,
  output logic               frame_end_o
);

  localparam int unsigned DEPTH = onod_pkg::QUEUE_DEPTH;
  localparam int unsigned QCW   = $clog2(DEPTH + 1);
  localparam int unsigned IDW   = onod_pkg::N_TAPS * ID_BITS;
  localparam int unsigned NMW   = onod_pkg::N_TAPS * onod_pkg::NRM_BITS;
  localparam int unsigned CTW   = $bits(onod_pkg::ctrl_t);
  localparam int unsigned QW    = CTW + IDW + NMW + onod_pkg::RGB_BITS;

  logic [10:0]        width_q;
  logic [11:0]        height_q;
  logic [23:0]        outline_q;
  logic signed [15:0] threshold_q;

  logic               q_push, q_pop;
  logic [QCW-1:0]     q_count;
  logic [QW-1:0]      q_wdata, q_rdata;

  onod_pkg::ctrl_t    f_ctrl, b_ctrl;
  logic [onod_pkg::N_TAPS-1:0][ID_BITS-1:0]            f_ids, b_ids;
  logic [onod_pkg::N_TAPS-1:0][onod_pkg::NRM_BITS-1:0] f_nrms, b_nrms;
  logic [onod_pkg::RGB_BITS-1:0]                       f_color, b_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= onod_pkg::WIDTH_RST;
      height_q    <= onod_pkg::HEIGHT_RST;
      outline_q   <= onod_pkg::OUTLINE_RST;
      threshold_q <= onod_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        onod_pkg::REG_WIDTH:     width_q     <= cfg_data_i[10:0];
        onod_pkg::REG_HEIGHT:    height_q    <= cfg_data_i[11:0];
        onod_pkg::REG_OUTLINE:   outline_q   <= cfg_data_i;
        onod_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  onod_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ID_BITS   (ID_BITS),
    .DEPTH     (DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .object_id_i   (object_id_i),
    .normal_x_i    (normal_x_i),
    .normal_y_i    (normal_y_i),
    .normal_z_i    (normal_z_i),
    .color_red_i   (color_red_i),
    .color_green_i (color_green_i),
    .color_blue_i  (color_blue_i),
    .cfg_width_i   (width_q),
    .cfg_height_i  (height_q),
    .q_count_i     (q_count),
    .push_o        (q_push),
    .ctrl_o        (f_ctrl),
    .ids_o         (f_ids),
    .nrms_o        (f_nrms),
    .color_o       (f_color)
  );

  assign q_wdata = {f_ctrl, f_ids, f_nrms, f_color};

  onod_fifo #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .count_o (q_count)
  );

  assign {b_ctrl, b_ids, b_nrms, b_color} = q_rdata;

  onod_back #(.ID_BITS(ID_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_nonempty_i    (q_count != '0),
    .pop_o           (q_pop),
    .ctrl_i          (b_ctrl),
    .ids_i           (b_ids),
    .nrms_i          (b_nrms),
    .color_i         (b_color),
    .cfg_outline_i   (outline_q),
    .cfg_threshold_i (threshold_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .is_edge_o       (is_edge_o),
    .frame_end_o     (frame_end_o)
  );

  // credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && (q_count == QCW'(DEPTH)) |-> q_pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_count != '0))
    else $error("queue pop while empty");

  // drained beats are never outline pixels
  a_end_not_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> !is_edge_o)
    else $error("frame end beat marked as edge");

  // a full queue closes the input
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == QCW'(DEPTH)) |-> in_stall_o)
    else $error("input open with full queue");

endmodule

### test/tb_object_normal_outline_detector_top.sv
// ----------------------------------------------------------------------------
// tb_object_normal_outline_detector_top
// Self-checking bench of the object/normal outline detector.
// ----------------------------------------------------------------------------
// Frames of pixel beats and flush beats are sent in raster order. A local
// outline predictor keeps its own line stores and counters and queues the
// pixel each beat should emit; every output beat is compared with the oldest
// queued pixel. Configuration is changed only between whole frames.
module tb_object_normal_outline_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXW = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       edge_flag;
    logic       fend;
  } pixel_out_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [7:0]  object_id;
  logic [15:0] normal_x, normal_y, normal_z;
  logic [7:0]  color_red, color_green, color_blue;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red, out_green, out_blue;
  logic        is_edge, frame_end;

  object_normal_outline_detector_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .func_i(func),
    .object_id_i(object_id), .normal_x_i(normal_x), .normal_y_i(normal_y),
    .normal_z_i(normal_z), .color_red_i(color_red), .color_green_i(color_green),
    .color_blue_i(color_blue), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_red_o(out_red), .out_green_o(out_green), .out_blue_o(out_blue),
    .is_edge_o(is_edge), .frame_end_o(frame_end)
  );

  // predictor state
  logic [7:0]  id_mem [2*MAXW];
  logic [47:0] nrm_mem [2*MAXW];
  logic [23:0] rgb_mem [MAXW];
  int unsigned col_cnt, row_cnt, drain_cnt;
  logic [10:0] reg_width;
  logic [11:0] reg_height;
  logic [23:0] reg_outline;
  logic [15:0] reg_threshold;

  pixel_out_t  pending_pixels[$];
  int unsigned fails;
  int unsigned beats_sent;
  bit          idle_on;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (reg_width < 3) return 3;
    if (reg_width > MAXW) return MAXW;
    return reg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height < 3) return 3;
    return reg_height;
  endfunction

  function automatic longint nrm_dot(logic [47:0] a, logic [47:0] b);
    return longint'($signed(a[47:32])) * longint'($signed(b[47:32]))
         + longint'($signed(a[31:16])) * longint'($signed(b[31:16]))
         + longint'($signed(a[15:0]))  * longint'($signed(b[15:0]));
  endfunction

  task automatic push_pixel(logic [23:0] rgb, logic e, logic f);
    pixel_out_t p;
    p.red = rgb[23:16];
    p.green = rgb[15:8];
    p.blue = rgb[7:0];
    p.edge_flag = e;
    p.fend = f;
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  task automatic predict_outline(logic fn, logic [7:0] id, logic [47:0] nrm,
                                 logic [23:0] rgb);
    int unsigned w, h, c, d, cur, ctr;
    logic [7:0]  cid;
    logic [7:0]  nid[4];
    logic [47:0] nn[4];
    logic [47:0] cn;
    longint      thr;
    logic        e, f;
    w = eff_width();
    h = eff_height();
    if (fn) begin
      if (row_cnt < h) return;
      d = (drain_cnt >= MAXW) ? MAXW - 1 : drain_cnt;
      f = (drain_cnt + 1 >= w);
      push_pixel(rgb_mem[d], 1'b0, f);
      if (f) begin
        drain_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
      end else begin
        drain_cnt++;
      end
      return;
    end
    if (row_cnt >= h) return;
    c = (col_cnt >= MAXW) ? MAXW - 1 : col_cnt;
    cur = (row_cnt & 1) * MAXW;
    if (row_cnt >= 1) begin
      ctr = ((row_cnt - 1) & 1) * MAXW;
      e = 1'b0;
      if (row_cnt >= 2 && c >= 1 && c + 1 < w) begin
        cid = id_mem[ctr + c];
        if (cid != 0) begin
          cn = nrm_mem[ctr + c];
          thr = longint'($signed(reg_threshold)) * 16384;
          nid[0] = id_mem[ctr + c - 1];  nn[0] = nrm_mem[ctr + c - 1];
          nid[1] = id_mem[ctr + c + 1];  nn[1] = nrm_mem[ctr + c + 1];
          nid[2] = id_mem[cur + c];      nn[2] = nrm_mem[cur + c];
          nid[3] = id;                   nn[3] = nrm;
          for (int k = 0; k < 4; k++) begin
            if (nid[k] != cid) e = 1'b1;
            if (nrm_dot(cn, nn[k]) < thr) e = 1'b1;
          end
        end
      end
      push_pixel(e ? reg_outline : rgb_mem[c], e, 1'b0);
    end
    id_mem[cur + c] = id;
    nrm_mem[cur + c] = nrm;
    rgb_mem[c] = rgb;
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  // drive one beat from a falling edge and hold it until accepted
  task automatic send_beat(logic fn, logic [7:0] id, logic [47:0] nrm, logic [23:0] rgb);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    func = fn;
    object_id = id;
    {normal_x, normal_y, normal_z} = nrm;
    {color_red, color_green, color_blue} = rgb;
    do @(posedge clk); while (in_stall);
    predict_outline(fn, id, nrm, rgb);
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [23:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      onod_pkg::REG_WIDTH:     reg_width = data[10:0];
      onod_pkg::REG_HEIGHT:    reg_height = data[11:0];
      onod_pkg::REG_OUTLINE:   reg_outline = data;
      onod_pkg::REG_THRESHOLD: reg_threshold = data[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_component(int unsigned mode);
    int signed v;
    case ($urandom_range(0, 3))
      0: v = 16384;
      1: v = -16384;
      2: v = 0;
      default: v = $urandom_range(0, 32768) - 16384;
    endcase
    if (mode == 1) return 16'($urandom);
    if (mode == 2) v = v + int'($urandom_range(0, 800)) - 400;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return 16'(v);
  endfunction

  // mode 0 blocky ids and in-range normals, 1 all bits random, 2 perturbed
  task automatic run_frame(logic [10:0] w, logic [11:0] h, int unsigned mode,
                           bit noisy);
    int unsigned ew, eh;
    logic [7:0]  id, last_id;
    logic [47:0] nrm, last_nrm;
    cfg_write(onod_pkg::REG_WIDTH, 24'(w));
    cfg_write(onod_pkg::REG_HEIGHT, 24'(h));
    ew = eff_width();
    eh = eff_height();
    last_id = 8'd1;
    last_nrm = {16'd0, 16'd0, 16'd16384};
    for (int unsigned i = 0; i < ew * eh; i++) begin
      if (noisy && $urandom_range(0, 20) == 0)
        send_beat(1'b1, 8'($urandom), 48'($urandom), 24'($urandom));
      if (mode == 1) begin
        id = 8'($urandom);
        nrm = {16'($urandom), 16'($urandom), 16'($urandom)};
      end else begin
        id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : last_id;
        if ($urandom_range(0, 3) == 0)
          nrm = {pick_component(mode), pick_component(mode), pick_component(mode)};
        else
          nrm = last_nrm;
      end
      last_id = id;
      last_nrm = nrm;
      send_beat(1'b0, id, nrm, 24'($urandom));
    end
    for (int unsigned i = 0; i < ew; i++) begin
      if (noisy && $urandom_range(0, 10) == 0)
        send_beat(1'b0, 8'($urandom), 48'($urandom), 24'($urandom));
      send_beat(1'b1, 8'($urandom), 48'($urandom), 24'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_directed();
    cfg_write(onod_pkg::REG_OUTLINE, 24'hFFFFFF);
    cfg_write(onod_pkg::REG_THRESHOLD, 24'(16'sd16384));
    run_frame(11'd3, 12'd3, 0, 1'b0);
    cfg_write(onod_pkg::REG_OUTLINE, 24'h000000);
    cfg_write(onod_pkg::REG_THRESHOLD, 24'(-16'sd16384));
    run_frame(11'd3, 12'd3, 1, 1'b1);
    cfg_write(onod_pkg::REG_THRESHOLD, 24'(16'sd9830));
    run_frame(11'd4, 12'd3, 2, 1'b1);
  endtask

  task automatic test_clamped_geometry();
    cfg_write(onod_pkg::REG_OUTLINE, 24'h0A0A0A);
    run_frame(11'd0, 12'd0, 0, 1'b0);
    run_frame(11'd2, 12'd1, 2, 1'b1);
    run_frame(11'd1, 12'd2, 1, 1'b0);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    run_frame(11'd8, 12'd6, 0, 1'b0);
  endtask

  task automatic test_random_frames(int unsigned target);
    while (beats_sent < target) begin
      if ($urandom_range(0, 1)) cfg_write(onod_pkg::REG_OUTLINE, 24'($urandom));
      case ($urandom_range(0, 3))
        0: cfg_write(onod_pkg::REG_THRESHOLD, 24'(16'($urandom)));
        1: cfg_write(onod_pkg::REG_THRESHOLD,
                     24'($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384));
        default: cfg_write(onod_pkg::REG_THRESHOLD,
                           24'(16'($urandom_range(8000, 16384))));
      endcase
      run_frame(11'($urandom_range(0, 9) == 0 ? $urandom_range(3, 40)
                                              : $urandom_range(3, 12)),
                12'($urandom_range(3, 8)), $urandom_range(0, 4) == 0 ? 1 : 2,
                $urandom_range(0, 1));
    end
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // output beat check and watchdog
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_object_normal_outline_detector_top NOT OK");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $error("output beat with no pixel expected");
          fails++;
        end else begin
          exp_px = pending_pixels.pop_front();
          if (out_red !== exp_px.red) begin
            $error("out_red exp %0h got %0h", exp_px.red, out_red); fails++;
          end
          if (out_green !== exp_px.green) begin
            $error("out_green exp %0h got %0h", exp_px.green, out_green); fails++;
          end
          if (out_blue !== exp_px.blue) begin
            $error("out_blue exp %0h got %0h", exp_px.blue, out_blue); fails++;
          end
          if (is_edge !== exp_px.edge_flag) begin
            $error("is_edge exp %0b got %0b", exp_px.edge_flag, is_edge); fails++;
          end
          if (frame_end !== exp_px.fend) begin
            $error("frame_end exp %0b got %0b", exp_px.fend, frame_end); fails++;
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_valid = 1'b0; func = 1'b0; object_id = '0;
    normal_x = '0; normal_y = '0; normal_z = '0;
    color_red = '0; color_green = '0; color_blue = '0;
    fails = 0; beats_sent = 0; quiet_cycles = 0;
    idle_on = 1'b1; hold_req = 1'b0;
    col_cnt = 0; row_cnt = 0; drain_cnt = 0;
    reg_width = onod_pkg::WIDTH_RST; reg_height = onod_pkg::HEIGHT_RST;
    reg_outline = onod_pkg::OUTLINE_RST; reg_threshold = onod_pkg::THRESHOLD_RST;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_clamped_geometry();
    test_backpressure();
    test_random_frames(beats_sent + 900);
    idle_on = 1'b0;
    test_random_frames(beats_sent + 200);
    wait_drained();
    if (pending_pixels.size() != 0) begin
      $error("%0d pixels never emitted", pending_pixels.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tb_object_normal_outline_detector_top OK");
    end else begin
      $display("tb_object_normal_outline_detector_top NOT OK");
    end
    $finish;
  end

endmodule
